/* design/ppbf_pkg.sv */
// ----------------------------------------------------------------------------
// ppbf_pkg
// Shared constant for the prime power base finder.
// ----------------------------------------------------------------------------
package ppbf_pkg;

   localparam int unsigned FIRST_DIVISOR = 2;

endpackage

/* design/prime_power_base_finder_core.sv */
// Timing: a value below two answers without any division. Otherwise each
// trial divisor takes one full pass of the shared restoring divider, and
// so does each further division-out of the prime factor. A prime near
// 2^VALUE_BITS needs about 2^(VALUE_BITS/2) trial divisors.
// Throughput: one item at a time. A new transfer is taken once the result is
// in the output register. Synchronous reset clears the sequencer and rsp_valid.
// ----------------------------------------------------------------------------
// prime_power_base_finder_core
// Trial division prime power test. A bit-serial divider is shared by the
// divisor search and the division-out loop under a small sequencer.
// ----------------------------------------------------------------------------
module prime_power_base_finder_core #(
   parameter int VALUE_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_base
);

   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VALUE_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);
   localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);
   localparam logic [VALUE_BITS-1:0] TWO = VALUE_BITS'(ppbf_pkg::FIRST_DIVISOR);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic                  strip_ff, strip_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] base_ff, base_in;
   logic [VALUE_BITS-1:0] res_ff, res_in;
   logic [VALUE_BITS-1:0] orig_ff, orig_in;
   logic [VALUE_BITS-1:0] rest_ff, rest_in;
   logic [VALUE_BITS-1:0] div_ff, div_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;
   logic                  req_take;

   assign trial     = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign diff      = trial - {1'b0, div_ff};
   assign fits      = trial >= {1'b0, div_ff};
   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_base  = base_ff;

   always_comb begin
      state_in     = state_ff;
      strip_in     = strip_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      base_in      = base_ff;
      res_in       = res_ff;
      orig_in      = orig_ff;
      rest_in      = rest_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_value < TWO) begin
                  res_in   = ONE;
                  state_in = S_FINISH;
               end else begin
                  orig_in  = req_value;
                  rest_in  = req_value;
                  div_in   = TWO;
                  strip_in = 1'b0;
                  quo_in   = req_value;
                  rem_in   = '0;
                  cnt_in   = CNT_LOAD;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            quo_in = {quo_ff[VALUE_BITS-2:0], fits};
            cnt_in = cnt_ff - CNT_LAST;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!strip_ff) begin
               if (div_ff > quo_ff) begin
                  res_in   = orig_ff;
                  state_in = S_FINISH;
               end else if (rem_ff == '0) begin
                  rest_in  = quo_ff;
                  strip_in = 1'b1;
                  rem_in   = '0;
                  cnt_in   = CNT_LOAD;
                  state_in = S_DIV;
               end else begin
                  div_in   = div_ff + ONE;
                  quo_in   = rest_ff;
                  rem_in   = '0;
                  cnt_in   = CNT_LOAD;
                  state_in = S_DIV;
               end
            end else begin
               if (rem_ff == '0) begin
                  rest_in  = quo_ff;
                  rem_in   = '0;
                  cnt_in   = CNT_LOAD;
                  state_in = S_DIV;
               end else begin
                  res_in   = (rest_ff == ONE) ? div_ff : ONE;
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               base_in      = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      strip_ff <= strip_in;
      base_ff  <= base_in;
      res_ff   <= res_in;
      orig_ff  <= orig_in;
      rest_ff  <= rest_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   a_divisor_at_least_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV || state_ff == S_CHECK) |-> div_ff >= TWO)
      else $error("trial divisor below two while dividing");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV || state_ff == S_CHECK) |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != S_IDLE)
      else $error("sequencer idle after taking a transfer");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside finish step");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks prime_power_base_finder_core: each transfer carries a positive
// integer and each answer must be its single prime base, or 1 when the value
// is not a prime power. A table of edge values runs first, then random values
// drawn from prime powers, small numbers, products and full-width numbers,
// limited to those that trial division settles in a bounded number of steps.
// Sender bursts and receiver stalls vary throughout; answers are checked in
// order against the table's bases or a local trial-division predictor.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          VALUE_BITS  = 40;
   localparam int          RANDOM_ITEMS = 80;
   localparam int unsigned COST_CAP    = 1100;
   localparam int unsigned IDLE_LIMIT  = 200000;
   localparam int unsigned LONG_HOLD   = 2000;
   localparam bit [63:0]   VALUE_MASK  = (64'd1 << VALUE_BITS) - 64'd1;

   typedef bit [VALUE_BITS-1:0] value_type;

   typedef struct {
      value_type value;
      value_type base;
      bit        base_known;
   } directed_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0] rsp_base;

   value_type      base_queue[$];
   int unsigned    error_count   = 0;
   int unsigned    results_seen  = 0;
   int unsigned    idle_cycles   = 0;
   int unsigned    hold_left     = 0;
   int unsigned    last_hold_at  = 0;
   int unsigned    mode_left     = 0;
   stall_mode_type stall_mode    = STALL_NONE;

   directed_row_type directed_rows [0:18] = '{
      '{40'd1,             40'd1,    1'b1},
      '{40'd2,             40'd2,    1'b1},
      '{40'd3,             40'd3,    1'b1},
      '{40'd4,             40'd2,    1'b1},
      '{40'd6,             40'd1,    1'b1},
      '{40'd9,             40'd3,    1'b1},
      '{40'd12,            40'd1,    1'b1},
      '{40'd30,            40'd1,    1'b1},
      '{40'hFF_FFFF_FFFF,  40'd1,    1'b1},
      '{40'hFF_FFFF_FFFE,  40'd1,    1'b1},
      '{40'h80_0000_0000,  40'd2,    1'b1},
      '{40'hC0_0000_0000,  40'd1,    1'b1},
      '{40'hAA_AAAA_AAAA,  40'd1,    1'b1},
      '{40'h55_5555_5555,  40'd0,    1'b0},
      '{40'd847288609443,  40'd3,    1'b1},
      '{40'd762939453125,  40'd5,    1'b1},
      '{40'd1042441,       40'd1021, 1'b1},
      '{40'd1048573,       40'd0,    1'b0},
      '{40'd600851475143,  40'd0,    1'b0}
   };

   prime_power_base_finder_core #(
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_base  (rsp_base)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Trial division; cost counts divisor trials and division-out steps.
   function automatic value_type find_prime_base(input value_type value,
                                                 output int unsigned cost);
      bit [63:0] rest;
      bit [63:0] divisor;
      cost = 0;
      rest = 64'(value);
      if (value < 2)
         return 1;
      for (divisor = 64'(ppbf_pkg::FIRST_DIVISOR); divisor <= rest / divisor;
           divisor++) begin
         cost++;
         if (rest % divisor == 0) begin
            while (rest % divisor == 0) begin
               rest = rest / divisor;
               cost++;
            end
            return (rest == 1) ? value_type'(divisor) : value_type'(1);
         end
      end
      return value;
   endfunction

   function automatic bit [63:0] random_prime_power();
      bit [63:0]   prime;
      bit [63:0]   power;
      int unsigned cost;
      int unsigned exponent;
      prime = 64'($urandom_range(2, 251));
      while (find_prime_base(value_type'(prime), cost) != value_type'(prime))
         prime = 64'($urandom_range(2, 251));
      power    = prime;
      exponent = $urandom_range(0, VALUE_BITS - 1);
      repeat (exponent)
         if (power <= VALUE_MASK / prime)
            power = power * prime;
      return power;
   endfunction

   task automatic pick_random_value(output value_type value, output value_type base);
      bit [63:0]   candidate;
      bit [63:0]   factor;
      int unsigned cost;
      bit          usable;
      usable = 1'b0;
      while (!usable) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               candidate = {$urandom, $urandom} & VALUE_MASK;
               if ($urandom_range(0, 3) == 0)
                  candidate = candidate >> $urandom_range(1, VALUE_BITS - 1);
            end
            5, 6: candidate = random_prime_power();
            7: candidate = 64'($urandom_range(2, 262143));
            8: begin
               candidate = random_prime_power();
               factor    = random_prime_power();
               if (candidate <= VALUE_MASK / factor)
                  candidate = candidate * factor;
            end
            default: candidate = VALUE_MASK - 64'($urandom_range(0, 1000));
         endcase
         base   = find_prime_base(value_type'(candidate), cost);
         usable = (candidate != 0) && (cost <= COST_CAP);
      end
      value = value_type'(candidate);
   endtask

   task automatic report_mismatch(input string what, input value_type got,
                                  input value_type want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Hold the item until it is taken, then record its answer.
   task automatic send_value(input value_type value, input value_type base);
      bit taken;
      req_valid <= 1'b1;
      req_value <= value;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      base_queue.push_back(base);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (base_queue.size() != 0)
         @(posedge clock);
   endtask

   int unsigned burst_left = 1;

   task automatic pace_sender();
      int unsigned gap;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         gap        = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      value_type   value;
      value_type   base;
      int unsigned cost;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         value = directed_rows[i].value;
         base  = directed_rows[i].base_known ? directed_rows[i].base
                                              : find_prime_base(value, cost);
         send_value(value, base);
         pace_sender();
      end
      drain_answers();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick_random_value(value, base);
         send_value(value, base);
         if (n == RANDOM_ITEMS / 2)
            drain_answers();
         else
            pace_sender();
      end
      drain_answers();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Receiver: random stall modes, with two long holds to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if ((results_seen == 30 || results_seen == 75) && last_hold_at != results_seen) begin
         rsp_stall    <= 1'b1;
         hold_left    <= LONG_HOLD;
         last_hold_at <= results_seen;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 2));
            mode_left  <= $urandom_range(5, 60);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:     rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (base_queue.size() == 0)
            report_mismatch("base with no value pending", rsp_base, '0);
         else if (rsp_base !== base_queue[0])
            report_mismatch("base", rsp_base, base_queue.pop_front());
         else
            void'(base_queue.pop_front());
      end
   end

   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles without a transfer", idle_cycles);
         $display("Verification failed");
         $finish;
      end
   end

endmodule
